// ----- src/round_robin_reference_cache_defines.svh -----
// Assertion macros shared by the round-robin reference cache RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROUND_ROBIN_REFERENCE_CACHE_DEFINES_SVH
`define ROUND_ROBIN_REFERENCE_CACHE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RRRC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define RRRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define RRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rrrc_pkg.sv -----
// Shared types and constants of the round-robin reference cache.
// No dependencies; imported by the controller, the datapath and the top level.
package rrrc_pkg;

    // Default ring depth
    localparam int SLOTS_DEF = 64;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int OBJ_W  = 32;
    localparam int OWN_W  = 8;
    localparam int SIZE_W = 7;

    // Sweep length after reset
    localparam logic [SIZE_W-1:0] SWEEP_RST = 7'd10;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PURGE_OBJ = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE_OWN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWEEP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESIZE    = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input word, start a command
        logic slot_rd;     // read the slot under the walk pointer
        logic ev;          // evaluate that slot, release on hit (not on insert), advance
        logic ins_rd;      // read the slot at the write index
        logic ins_commit;  // evict and overwrite the slot at the write index
        logic fin;         // apply resize, close the command
        logic buf_rd;      // read the next released handle
        logic out_buf;     // load the output with a released handle
        logic out_empty;   // load the output with the empty result
    } t_dp_ctl;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_go;     // command needs a slot walk
        logic stop;        // slot under evaluation ends the walk
        logic ins_next;    // insert walk ended with the object absent
        logic rel_none;    // nothing released by this command
        logic buf_last;    // handle being output is the last one
        logic out_free;    // output register can take a word
    } t_dp_sts;

endpackage

// ----- src/rrrc_ctrl.sv -----
// Controller state machine of the round-robin reference cache.
// Depends on rrrc_pkg; drives the datapath through t_dp_ctl, reads t_dp_sts.
module rrrc_ctrl import rrrc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_EV     = 4'd3;
    localparam logic [3:0] S_INS_RD = 4'd4;
    localparam logic [3:0] S_INS_EV = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_EMPTY  = 4'd7;
    localparam logic [3:0] S_BUF_RD = 4'd8;
    localparam logic [3:0] S_BUF_LD = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence one command: walk, optional insert, then drain results
    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.walk_go ? S_RD : S_FIN;
            end
            S_RD: begin
                o_ctl.slot_rd = 1'b1;
                n_state       = S_EV;
            end
            S_EV: begin
                o_ctl.ev = 1'b1;
                if (i_sts.stop) begin
                    n_state = i_sts.ins_next ? S_INS_RD : S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_INS_RD: begin
                o_ctl.ins_rd = 1'b1;
                n_state      = S_INS_EV;
            end
            S_INS_EV: begin
                o_ctl.ins_commit = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = i_sts.rel_none ? S_EMPTY : S_BUF_RD;
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_ctl.out_empty = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_BUF_RD: begin
                o_ctl.buf_rd = 1'b1;
                n_state      = S_BUF_LD;
            end
            S_BUF_LD: begin
                if (i_sts.out_free) begin
                    o_ctl.out_buf = 1'b1;
                    n_state       = i_sts.buf_last ? S_IDLE : S_BUF_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/rrrc_dp.sv -----
// Datapath of the round-robin reference cache: slot memories, valid bits,
// ring pointers, release buffer and output register. Depends on rrrc_pkg
// and the assertion macros.
`include "round_robin_reference_cache_defines.svh"

module rrrc_dp import rrrc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OBJ_W-1:0]  i_object_id,
    input  logic [OWN_W-1:0]  i_owner_id,
    input  logic [SIZE_W-1:0] i_new_size,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_released_valid,
    output logic [OBJ_W-1:0]  o_released_object,
    output logic              o_last_result,
    output logic [SIZE_W-1:0] o_entry_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Slot storage and release buffer
    logic [OBJ_W-1:0] r_mem_obj [SLOTS];
    logic [OWN_W-1:0] r_mem_own [SLOTS];
    logic [OBJ_W-1:0] r_rel_mem [SLOTS];

    logic [SLOTS-1:0]  r_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [OBJ_W-1:0]  r_obj;
    logic [OWN_W-1:0]  r_own;
    logic [CW-1:0]     r_nsz;
    logic [CW-1:0]     r_idx;
    logic [SIZE_W-1:0] r_step;
    logic [IW-1:0]     r_wi;
    logic [CW-1:0]     r_occ;
    logic [CW-1:0]     r_active;
    logic [SIZE_W-1:0] r_sweep_cnt;
    logic [OBJ_W-1:0]  r_rd_obj;
    logic [OWN_W-1:0]  r_rd_own;
    logic [CW-1:0]     r_rel_cnt;
    logic [CW-1:0]     r_rel_rd;
    logic [OBJ_W-1:0]  r_buf_obj;
    logic              r_out_valid;
    logic              r_out_rel;
    logic [OBJ_W-1:0]  r_out_obj;
    logic              r_out_last;
    logic [SIZE_W-1:0] r_out_cnt;

    logic [CW-1:0]     w_nsz_sat;
    logic [IW-1:0]     w_addr;
    logic [IW-1:0]     w_rd_addr;
    logic              w_hit;
    logic              w_release;
    logic [CW-1:0]     w_wi_inc;
    logic [IW-1:0]     w_wi_next;
    logic              w_last_slot;
    logic              w_out_free;

    // Saturate the requested size at the ring depth
    assign w_nsz_sat = (i_new_size > SIZE_W'(SLOTS)) ? CW'(SLOTS) : i_new_size[CW-1:0];

    // Sweeps walk from the write index, all other walks use the slot pointer
    assign w_addr    = (r_cmd == CMD_SWEEP) ? r_wi : r_idx[IW-1:0];
    assign w_rd_addr = i_ctl.ins_rd ? r_wi : w_addr;

    // Advance the write index, wrap at the active size
    assign w_wi_inc  = CW'(r_wi) + CW'(1);
    assign w_wi_next = (w_wi_inc >= r_active || w_wi_inc >= CW'(SLOTS)) ?
                       '0 : w_wi_inc[IW-1:0];

    assign w_last_slot = (r_idx == CW'(SLOTS - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Slot hit per command
    always_comb begin
        unique case (r_cmd)
            CMD_INSERT, CMD_PURGE_OBJ: w_hit = r_valid[w_addr] && (r_rd_obj == r_obj);
            CMD_PURGE_OWN:             w_hit = r_valid[w_addr] && (r_rd_own == r_own);
            CMD_SWEEP, CMD_RESIZE:     w_hit = r_valid[w_addr];
            default:                   w_hit = 1'b0;
        endcase
    end

    // A hit on insert means the object is held already: nothing released
    assign w_release = (i_ctl.ev && w_hit && (r_cmd != CMD_INSERT)) ||
                       (i_ctl.ins_commit && r_valid[r_wi]);

    // Status toward the controller
    always_comb begin
        o_sts = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                o_sts.walk_go = (r_active != '0);
                o_sts.stop    = w_hit || w_last_slot;
            end
            CMD_PURGE_OBJ: begin
                o_sts.walk_go = 1'b1;
                o_sts.stop    = w_hit || w_last_slot;
            end
            CMD_PURGE_OWN: begin
                o_sts.walk_go = 1'b1;
                o_sts.stop    = w_last_slot;
            end
            CMD_SWEEP: begin
                o_sts.walk_go = (r_occ != '0) && (r_active != '0) && (r_sweep_cnt != '0);
                o_sts.stop    = ((r_step + SIZE_W'(1)) == r_sweep_cnt);
            end
            CMD_RESIZE: begin
                o_sts.walk_go = (r_nsz < r_active);
                o_sts.stop    = ((r_idx + CW'(1)) == r_active);
            end
            default: begin
                o_sts.walk_go = 1'b0;
                o_sts.stop    = 1'b1;
            end
        endcase
        o_sts.ins_next = (r_cmd == CMD_INSERT) && !w_hit;
        o_sts.rel_none = (r_rel_cnt == '0);
        o_sts.buf_last = ((r_rel_rd + CW'(1)) == r_rel_cnt);
        o_sts.out_free = w_out_free;
    end

    // Slot memories: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.slot_rd || i_ctl.ins_rd) begin
            r_rd_obj <= r_mem_obj[w_rd_addr];
            r_rd_own <= r_mem_own[w_rd_addr];
        end
        if (i_ctl.ins_commit) begin
            r_mem_obj[r_wi] <= r_obj;
            r_mem_own[r_wi] <= r_own;
        end
    end

    // Release buffer: push released handles, read them back in order
    always_ff @(posedge i_clk) begin
        if (w_release) begin
            r_rel_mem[r_rel_cnt[IW-1:0]] <= r_rd_obj;
        end
        if (i_ctl.buf_rd) begin
            r_buf_obj <= r_rel_mem[r_rel_rd[IW-1:0]];
        end
    end

    // Latch the command word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_command;
            r_obj <= i_object_id;
            r_own <= i_owner_id;
            r_nsz <= w_nsz_sat;
        end
    end

    // Ring state, walk pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_wi        <= '0;
            r_occ       <= '0;
            r_active    <= CW'(SLOTS);
            r_sweep_cnt <= SWEEP_RST;
            r_idx       <= '0;
            r_step      <= '0;
            r_rel_cnt   <= '0;
            r_rel_rd    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sweep_cnt <= i_cfg_wr_data;
            end
            if (i_ctl.load) begin
                r_idx     <= (i_command == CMD_RESIZE) ? w_nsz_sat : '0;
                r_step    <= '0;
                r_rel_cnt <= '0;
                r_rel_rd  <= '0;
            end
            if (w_release) begin
                r_rel_cnt <= r_rel_cnt + CW'(1);
            end
            // Walk one slot
            if (i_ctl.ev) begin
                if (r_cmd == CMD_SWEEP) begin
                    r_step <= r_step + SIZE_W'(1);
                    r_wi   <= w_wi_next;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
                if (w_release) begin
                    r_valid[w_addr] <= 1'b0;
                    r_occ           <= r_occ - CW'(1);
                end
            end
            // Evict and overwrite at the write index
            if (i_ctl.ins_commit) begin
                r_valid[r_wi] <= 1'b1;
                r_wi          <= w_wi_next;
                if (!r_valid[r_wi]) begin
                    r_occ <= r_occ + CW'(1);
                end
            end
            // Apply a resize; pull the write index back inside the ring
            if (i_ctl.fin && (r_cmd == CMD_RESIZE)) begin
                r_active <= r_nsz;
                if (CW'(r_wi) >= r_nsz) begin
                    r_wi <= '0;
                end
            end
            if (i_ctl.out_buf) begin
                r_rel_rd <= r_rel_rd + CW'(1);
            end
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.out_buf || i_ctl.out_empty) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_buf) begin
            r_out_rel  <= 1'b1;
            r_out_obj  <= r_buf_obj;
            r_out_last <= o_sts.buf_last;
            r_out_cnt  <= SIZE_W'(r_occ);
        end else if (i_ctl.out_empty) begin
            r_out_rel  <= 1'b0;
            r_out_obj  <= '0;
            r_out_last <= 1'b1;
            r_out_cnt  <= SIZE_W'(r_occ);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_released_valid  = r_out_rel;
    assign o_released_object = r_out_obj;
    assign o_last_result     = r_out_last;
    assign o_entry_count     = r_out_cnt;

    // Occupancy tracks the valid bits exactly
    `RRRC_ASSERT_ALWAYS(a_occ_matches_valid, i_clk, i_rst_n,
        r_occ == CW'($countones(r_valid)), "occupied count differs from valid bits")
    // Write index stays inside the active ring
    `RRRC_ASSERT_IMPL(a_wi_in_ring, i_clk, i_rst_n,
        r_active != '0, CW'(r_wi) < r_active, "write index outside active ring")
    // An insert always leaves at least one occupied slot
    `RRRC_ASSERT_NEXT(a_insert_occupies, i_clk, i_rst_n,
        i_ctl.ins_commit, r_occ != '0, "insert left the ring empty")

endmodule

// ----- src/round_robin_reference_cache.sv -----
// Top level of the round-robin reference cache: controller plus datapath.
// Depends on rrrc_pkg, rrrc_ctrl and rrrc_dp.
//
//   Channel   Handshake                    Word
//   input     i_in_valid / o_in_ready      i_command, i_object_id, i_owner_id, i_new_size
//   output    o_out_valid / i_out_ready    o_released_valid, o_released_object,
//                                          o_last_result, o_entry_count
//   config    i_cfg_wr_en                  i_cfg_wr_data (sweep count)
//
// One command at a time; each walked slot is read through the single read port
// of the slot memory, then evaluated. Insert and purge walk up to SLOTS slots,
// sweep walks sweep_count slots, resize walks the dropped slots; an insert of an
// absent object then reads and overwrites the slot at the write index. Each
// result is then read from the release buffer and loaded into the output register.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled output holds its word; the next command is taken once the last
// result sits in the output register.
module round_robin_reference_cache import rrrc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OBJ_W-1:0]  i_object_id,
    input  logic [OWN_W-1:0]  i_owner_id,
    input  logic [SIZE_W-1:0] i_new_size,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_released_valid,
    output logic [OBJ_W-1:0]  o_released_object,
    output logic              o_last_result,
    output logic [SIZE_W-1:0] o_entry_count,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // Command sequencer
    rrrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // Ring storage and result path
    rrrc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_command         (i_command),
        .i_object_id       (i_object_id),
        .i_owner_id        (i_owner_id),
        .i_new_size        (i_new_size),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_released_valid  (o_released_valid),
        .o_released_object (o_released_object),
        .o_last_result     (o_last_result),
        .o_entry_count     (o_entry_count)
    );

endmodule
